// ----- src/dr_pkg.sv -----
// Package of the difficulty retarget block: constants, pipeline types and the
// compact-bits decode, encode and constant-divider step functions.
// Depends on nothing; the top level and the testbench use it.
package dr_pkg;

  // Chain constants.
  localparam longint RetargetInterval = 2016;
  localparam longint TargetTimespan   = 1209600;
  localparam logic [31:0] LimitReset  = 32'h1d00ffff;

  // Encoding of the limit when it does not fit in 256 bits (2^256 - 1).
  localparam logic [31:0] LimitOverEnc = 32'h2100ffff;

  // Timespan clamp bounds.
  localparam logic [31:0] SpanLo = 32'(TargetTimespan / 4);
  localparam logic [31:0] SpanHi = 32'(TargetTimespan * 4);

  // Reciprocal for the height modulo check: floor(x * RecMul / 2^(32 + RecL)).
  localparam int RecL = $clog2(RetargetInterval);
  localparam logic [32:0] RecMul = 33'(((64'd1 << (32 + RecL)) / RetargetInterval) + 1);
  localparam int ProdW = 65;

  // Divider widths: remainder of a division by the target timespan.
  localparam int RW = $clog2(TargetTimespan);
  localparam int VmW = 23;
  localparam int SpanW = 32;
  localparam int AW = VmW + SpanW;
  localparam int FracW = 64;
  localparam int NumW = AW + FracW;
  localparam int ND = (NumW + 7) / 8;
  localparam int NumPadW = ND * 8;
  localparam int QW = 96;
  localparam int SbW = 6;

  // Pipeline stage indexes.
  localparam int StIn = 0;
  localparam int StMul = 1;
  localparam int StDiv = 2;
  localparam int StAlign = StDiv + ND;
  localparam int StCmp = StAlign + 1;
  localparam int StEnc = StCmp + 1;
  localparam int NS = StEnc + 1;

  // Decoded compact value: value = vm * 2^(8 * sb), over when beyond 256 bits.
  typedef struct packed {
    logic [VmW-1:0] vm;
    logic [SbW-1:0] sb;
    logic           over;
  } dec_t;

  // Decoded limit, kept in registers next to the configuration.
  typedef struct packed {
    logic [VmW-1:0] ml;
    logic [SbW-1:0] i;
    logic           ovl;
    logic [31:0]    enc;
  } lim_t;

  // One constant-divider step of eight quotient bits.
  typedef struct packed {
    logic [RW-1:0] rem;
    logic [7:0]    q;
  } div_t;

  // Payload that travels down the pipeline.
  typedef struct packed {
    logic [31:0]      bits;
    logic [31:0]      h1;
    logic [ProdW-1:0] prod;
    logic             retgt;
    logic             over;
    logic [SbW-1:0]   sb;
    logic [VmW-1:0]   vm;
    logic [SpanW-1:0] span;
    logic [AW-1:0]    a;
    logic [RW-1:0]    rem;
    logic [QW-1:0]    quo;
    logic [QW-1:0]    kp;
    logic [SbW-1:0]   j;
    logic             low;
    logic             hit;
    logic [31:0]      nxt;
  } pipe_t;

  // Decode compact bits; the sign bit is ignored.
  function automatic dec_t decode(input logic [31:0] bits);
    dec_t        r;
    logic [7:0]  e;
    logic [22:0] m;
    r = '0;
    e = bits[31:24];
    m = bits[22:0];
    if (m == '0) begin
      r = '0;
    end else if (e <= 8'd3) begin
      r.vm = m >> (5'(8 * (3 - int'(e))));
    end else begin
      r.vm = m;
      r.sb = SbW'(e - 8'd3);
      r.over = (e > 8'd34) || ((e == 8'd34) && (m[22:8] != '0)) ||
               ((e == 8'd33) && (m[22:16] != '0));
    end
    return r;
  endfunction

  // Encode mant * 2^(8 * j) in minimal compact form.
  function automatic logic [31:0] encode(input logic [QW-1:0] mant, input logic [SbW-1:0] j);
    logic [3:0]     nb;
    logic [QW+23:0] w;
    logic [23:0]    c;
    logic [7:0]     size;
    nb = '0;
    for (int b = 0; b < QW / 8; b++) begin
      if (mant[8*b +: 8] != '0) nb = 4'(b + 1);
    end
    w = {mant, 24'h0} >> (7'(8 * int'(nb)));
    c = w[23:0];
    size = 8'(nb) + 8'(j);
    if (c[23]) begin
      c = c >> 8;
      size = size + 8'd1;
    end
    return {size, c};
  endfunction

  // Decode the limit; one beyond 256 bits stands for 2^256 - 1.
  function automatic lim_t decode_limit(input logic [31:0] bits);
    lim_t r;
    dec_t d;
    d = decode(bits);
    if (d.over) begin
      r.ml = VmW'(1);
      r.i = SbW'(32);
      r.ovl = 1'b1;
      r.enc = LimitOverEnc;
    end else begin
      r.ml = d.vm;
      r.i = d.sb;
      r.ovl = 1'b0;
      r.enc = encode(QW'(d.vm), d.sb);
    end
    return r;
  endfunction

  // Eight restoring division steps by the target timespan.
  function automatic div_t div_byte(input logic [RW-1:0] rem, input logic [7:0] num);
    div_t        r;
    logic [RW:0] t;
    r.rem = rem;
    r.q = '0;
    for (int b = 7; b >= 0; b--) begin
      t = {r.rem, num[b]};
      if (t >= (RW+1)'(TargetTimespan)) begin
        t = t - (RW+1)'(TargetTimespan);
        r.q[b] = 1'b1;
      end
      r.rem = t[RW-1:0];
    end
    return r;
  endfunction

  localparam lim_t LimResetDec = decode_limit(LimitReset);

endpackage

// ----- src/dr_if.sv -----
// Valid/ready channel interfaces of the difficulty retarget block.
// Depends on nothing; the top level takes one input and one output channel.
interface dr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] last_height;
  logic [31:0] last_bits;
  logic [31:0] last_timestamp;
  logic [31:0] first_timestamp;

  modport source (output valid, last_height, last_bits, last_timestamp, first_timestamp,
                  input ready);
  modport sink (input valid, last_height, last_bits, last_timestamp, first_timestamp,
                output ready);
endinterface

interface dr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_bits;
  logic        retargeted;
  logic        hit_limit;

  modport source (output valid, next_bits, retargeted, hit_limit, input ready);
  modport sink (input valid, next_bits, retargeted, hit_limit, output ready);
endinterface

// ----- src/difficulty_retarget.sv -----
// Top level of the difficulty retarget block: a pipeline that computes the
// next compact difficulty bits. Uses dr_pkg and the channels in dr_if.sv.
//
// Usage: each input transaction on in_i carries the last block's height,
// bits and timestamp and the interval's first timestamp. Each one gives
// exactly one output transaction on out_o, in order: next_bits, and the
// retargeted and hit_limit flags.
// Throughput: one transaction per cycle while the receiver does not stall;
// out_o.valid rises once a transaction has passed every stage, and the
// depth is set by the fifteen stages of the constant divider (eight
// quotient bits a stage) plus input, multiply, align, compare and encode.
// The user must write the limit register with limit_we_i and limit_wdata_i while
// the pipeline is empty (not enforced here); it applies to the next transaction.
// Reset: rst_ni clears all stage valid bits and loads the default limit.
// Stall: when out_o.ready is low, the output stage holds; earlier stages
// keep filling bubbles, and in_i.ready falls only when every stage is full.
module difficulty_retarget (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        limit_we_i,
  input  logic [31:0] limit_wdata_i,
  dr_in_if.sink       in_i,
  dr_out_if.source    out_o
);

  dr_pkg::pipe_t st_q [dr_pkg::NS];
  dr_pkg::pipe_t st_d [dr_pkg::NS];
  logic [dr_pkg::NS-1:0] vq_q;
  logic [dr_pkg::NS-1:0] vq_d;
  logic [dr_pkg::NS:0]   en;
  dr_pkg::lim_t lim_q;

  // Limit register, kept in decoded form.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= dr_pkg::LimResetDec;
    end else if (limit_we_i) begin
      lim_q <= dr_pkg::decode_limit(limit_wdata_i);
    end
  end

  // Stage enables: a stage loads when it is empty or the next one moves.
  always_comb begin
    en[dr_pkg::NS] = out_o.ready;
    for (int k = dr_pkg::NS - 1; k >= 0; k--) begin
      en[k] = !vq_q[k] || en[k+1];
    end
    vq_d[0] = in_i.valid;
    for (int k = 1; k < dr_pkg::NS; k++) begin
      vq_d[k] = vq_q[k-1];
    end
  end

  assign in_i.ready = en[0];

  // Stage datapath.
  always_comb begin
    dr_pkg::dec_t  dec;
    logic [31:0]   span;
    logic [31:0]   q;
    logic [dr_pkg::NumPadW-1:0] num;
    dr_pkg::div_t  dv;
    logic [dr_pkg::RW-1:0] rin;
    logic [3:0]    msb;
    logic [dr_pkg::SbW-1:0] diff;
    logic [3:0]    sh;
    logic [dr_pkg::QW+23:0] lx;
    logic [dr_pkg::QW+23:0] kx;
    logic          gt;
    logic          eq;

    // Input stage: height + 1, clamped timespan, decoded last bits.
    st_d[dr_pkg::StIn] = '0;
    dec = dr_pkg::decode(in_i.last_bits);
    span = in_i.last_timestamp - in_i.first_timestamp;
    if (span < dr_pkg::SpanLo) span = dr_pkg::SpanLo;
    if (span > dr_pkg::SpanHi) span = dr_pkg::SpanHi;
    st_d[dr_pkg::StIn].bits = in_i.last_bits;
    st_d[dr_pkg::StIn].h1 = in_i.last_height + 32'd1;
    st_d[dr_pkg::StIn].vm = dec.vm;
    st_d[dr_pkg::StIn].sb = dec.sb;
    st_d[dr_pkg::StIn].over = dec.over;
    st_d[dr_pkg::StIn].span = span;

    for (int k = 1; k < dr_pkg::NS; k++) begin
      st_d[k] = st_q[k-1];
    end

    // Multiply stage: reciprocal product for the height check, target times span.
    st_d[dr_pkg::StMul].prod = dr_pkg::ProdW'(st_q[dr_pkg::StIn].h1) *
                               dr_pkg::ProdW'(dr_pkg::RecMul);
    st_d[dr_pkg::StMul].a = dr_pkg::AW'(st_q[dr_pkg::StIn].vm) *
                            dr_pkg::AW'(st_q[dr_pkg::StIn].span);

    // Height check rides along with the first divider stage.
    q = 32'(st_q[dr_pkg::StMul].prod >> (32 + dr_pkg::RecL));
    st_d[dr_pkg::StDiv].retgt = ((48'(q) * 48'(dr_pkg::RetargetInterval)) ==
                                48'(st_q[dr_pkg::StMul].h1));

    // Divider: (a * 2^64) / timespan, eight quotient bits a stage.
    for (int d = 0; d < dr_pkg::ND; d++) begin
      num = {(dr_pkg::NumPadW - 64)'(st_q[dr_pkg::StDiv+d-1].a), 64'h0};
      rin = (d == 0) ? '0 : st_q[dr_pkg::StDiv+d-1].rem;
      dv = dr_pkg::div_byte(rin, num[dr_pkg::NumPadW-1-8*d -: 8]);
      st_d[dr_pkg::StDiv+d].rem = dv.rem;
      st_d[dr_pkg::StDiv+d].quo = (d == 0) ? dr_pkg::QW'(dv.q) :
                                  {st_q[dr_pkg::StDiv+d-1].quo[dr_pkg::QW-9:0], dv.q};
    end

    // Align: top of the quotient and its byte offset, plus the sticky bit below it.
    msb = (st_q[dr_pkg::StAlign-1].sb > 6'd8) ? 4'd8 : 4'(st_q[dr_pkg::StAlign-1].sb);
    st_d[dr_pkg::StAlign].kp = st_q[dr_pkg::StAlign-1].quo >> (7'(64 - 8 * int'(msb)));
    st_d[dr_pkg::StAlign].j = (st_q[dr_pkg::StAlign-1].sb > 6'd8) ?
                              st_q[dr_pkg::StAlign-1].sb - 6'd8 : '0;
    if (st_d[dr_pkg::StAlign].j >= 6'd4) begin
      st_d[dr_pkg::StAlign].low = (st_q[dr_pkg::StAlign-1].rem != '0);
    end else begin
      st_d[dr_pkg::StAlign].low = ((64'(st_q[dr_pkg::StAlign-1].rem) <<
                                   (6'(8 * int'(st_d[dr_pkg::StAlign].j)))) >=
                                   64'(dr_pkg::TargetTimespan));
    end

    // Compare the new target against the limit, both as mantissa and byte offset.
    diff = '0;
    sh = '0;
    lx = '0;
    kx = (dr_pkg::QW+24)'(st_q[dr_pkg::StCmp-1].kp);
    gt = 1'b0;
    eq = 1'b0;
    if (lim_q.i < st_q[dr_pkg::StCmp-1].j) begin
      gt = (st_q[dr_pkg::StCmp-1].kp != '0);
    end else begin
      diff = lim_q.i - st_q[dr_pkg::StCmp-1].j;
      sh = (diff > 6'd12) ? 4'd12 : 4'(diff);
      lx = (dr_pkg::QW+24)'(lim_q.ml) << (7'(8 * int'(sh)));
      gt = kx > lx;
      eq = kx == lx;
    end
    st_d[dr_pkg::StCmp].hit = st_q[dr_pkg::StCmp-1].over || gt ||
                              (eq && (lim_q.ovl || st_q[dr_pkg::StCmp-1].low));

    // Encode, or use the limit's encoding on a hit, or pass the last bits through.
    if (!st_q[dr_pkg::StEnc-1].retgt) begin
      st_d[dr_pkg::StEnc].nxt = st_q[dr_pkg::StEnc-1].bits;
      st_d[dr_pkg::StEnc].hit = 1'b0;
    end else if (st_q[dr_pkg::StEnc-1].hit) begin
      st_d[dr_pkg::StEnc].nxt = lim_q.enc;
    end else begin
      st_d[dr_pkg::StEnc].nxt = dr_pkg::encode(st_q[dr_pkg::StEnc-1].kp,
                                               st_q[dr_pkg::StEnc-1].j);
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= '0;
    end else begin
      for (int k = 0; k < dr_pkg::NS; k++) begin
        if (en[k]) vq_q[k] <= vq_d[k];
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < dr_pkg::NS; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  assign out_o.valid = vq_q[dr_pkg::NS-1];
  assign out_o.next_bits = st_q[dr_pkg::NS-1].nxt;
  assign out_o.retargeted = st_q[dr_pkg::NS-1].retgt;
  assign out_o.hit_limit = st_q[dr_pkg::NS-1].hit;

`ifndef SYNTHESIS
  // The limit flag is only raised on a retarget.
  a_hit_needs_retarget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.hit_limit |-> out_o.retargeted)
    else $error("hit_limit without retarget");

  // A freshly encoded target never carries the sign bit.
  a_no_sign_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.retargeted |-> !out_o.next_bits[23])
    else $error("encoded bits have the sign bit set");

  // Input backpressure only when every stage holds a transaction.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&vq_q) && !out_o.ready)
    else $error("input stalled while the pipeline has a bubble");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the difficulty retarget block: directed table, then
// random headers, against a wide-integer predictor. Uses dr_pkg and dr_if.sv.
module testbench;

  localparam int IdleLimit = 5000;
  localparam int DrainCycles = 30;
  localparam int PhaseItems = 270;

  typedef struct packed {
    logic [31:0] next_bits;
    logic        retargeted;
    logic        hit_limit;
  } retarget_res_t;

  typedef struct packed {
    logic [31:0]   height;
    logic [31:0]   bits;
    logic [31:0]   t_last;
    logic [31:0]   t_first;
    logic          typed;
    retarget_res_t res;
  } header_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        limit_we_i;
  logic [31:0] limit_wdata_i;

  dr_in_if  in_if ();
  dr_out_if out_if ();

  difficulty_retarget u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .limit_we_i   (limit_we_i),
    .limit_wdata_i(limit_wdata_i),
    .in_i         (in_if),
    .out_o        (out_if)
  );

  // Model copy of the limit register and the queue of awaited results.
  logic [31:0]   limit_reg;
  retarget_res_t awaited_q[$];
  int            errors;
  int            idle_cycles;
  bit            no_idle;
  bit            hold_req;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decode compact bits into a wide value; returns 1 when it exceeds 256 bits.
  function automatic bit decode_wide(input logic [31:0] b, output logic [287:0] v);
    int          e;
    logic [22:0] m;
    e = int'(b[31:24]);
    m = b[22:0];
    v = '0;
    if (m == '0) return 1'b0;
    if (e <= 3) begin
      v = 288'(m >> (8 * (3 - e)));
      return 1'b0;
    end
    if (e > 34) return 1'b1;
    v = 288'(m) << (8 * (e - 3));
    return v[287:256] != '0;
  endfunction

  // Minimal compact encoding of a 256-bit value.
  function automatic logic [31:0] encode_wide(input logic [255:0] v);
    int          size;
    logic [31:0] c;
    size = 0;
    for (int i = 0; i < 32; i++) begin
      if (v[8*i +: 8] != '0) size = i + 1;
    end
    if (size == 0) return '0;
    if (size <= 3) c = 32'(v[31:0] << (8 * (3 - size)));
    else c = 32'(v >> (8 * (size - 3))) & 32'h00ffffff;
    if (c[23]) begin
      c = c >> 8;
      size++;
    end
    return c | (32'(size) << 24);
  endfunction

  // Next compact bits for one header under the current limit.
  function automatic retarget_res_t next_target(input logic [31:0] height,
                                                input logic [31:0] bits,
                                                input logic [31:0] t_last,
                                                input logic [31:0] t_first);
    retarget_res_t r;
    logic [287:0]  lim;
    logic [287:0]  tgt;
    logic [319:0]  prod;
    logic [31:0]   span;
    logic [31:0]   h1;
    bit            over;
    h1 = height + 32'd1;
    if (h1 % 32'(dr_pkg::RetargetInterval) != 0) begin
      r.next_bits = bits;
      r.retargeted = 1'b0;
      r.hit_limit = 1'b0;
      return r;
    end
    if (decode_wide(limit_reg, lim)) lim = {32'h0, {256{1'b1}}};
    span = t_last - t_first;
    if (span < dr_pkg::SpanLo) span = dr_pkg::SpanLo;
    if (span > dr_pkg::SpanHi) span = dr_pkg::SpanHi;
    over = decode_wide(bits, tgt);
    if (!over) begin
      prod = 320'(tgt) * 320'(span);
      prod = prod / 320'(dr_pkg::TargetTimespan);
      tgt = prod[287:0];
    end
    r.retargeted = 1'b1;
    r.hit_limit = over || (tgt > lim);
    if (r.hit_limit) tgt = lim;
    r.next_bits = encode_wide(tgt[255:0]);
    return r;
  endfunction

  // Random gap length: mostly none or short, a few long.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  // Offer one transaction and hold it until accepted; then queue its result.
  task automatic send_header(input header_row_t row);
    int g;
    in_if.valid <= 1'b1;
    in_if.last_height <= row.height;
    in_if.last_bits <= row.bits;
    in_if.last_timestamp <= row.t_last;
    in_if.first_timestamp <= row.t_first;
    do @(posedge clk_i); while (!in_if.ready);
    if (row.typed) awaited_q.push_back(row.res);
    else awaited_q.push_back(next_target(row.height, row.bits, row.t_last, row.t_first));
    g = draw_gap();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Let the pipeline empty out completely.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [31:0] value);
    limit_we_i <= 1'b1;
    limit_wdata_i <= value;
    @(posedge clk_i);
    limit_we_i <= 1'b0;
    limit_reg = value;
  endtask

  // Random header, biased toward interval boundaries and interesting exponents.
  function automatic header_row_t random_header();
    header_row_t row;
    logic [31:0] k;
    row = '0;
    if ($urandom_range(9) < 6) begin
      k = $urandom_range(2130440, 0);
      row.height = 32'(k * 32'(dr_pkg::RetargetInterval)) - 32'd1;
    end else begin
      row.height = $urandom;
    end
    case ($urandom_range(3))
      0: row.bits = $urandom;
      1: row.bits = {8'($urandom_range(36, 0)), 1'($urandom), 23'($urandom)};
      2: row.bits = {8'($urandom_range(8'h1d, 8'h1b)), 1'($urandom), 7'($urandom_range(1, 0)),
                     16'($urandom)};
      default: row.bits = {8'($urandom_range(35, 32)), 1'($urandom), 23'($urandom)};
    endcase
    row.t_first = $urandom;
    case ($urandom_range(3))
      0: row.t_last = $urandom;
      1: row.t_last = row.t_first + $urandom_range(dr_pkg::SpanHi + 100000,
                                                   dr_pkg::SpanLo - 100000);
      2: row.t_last = row.t_first + $urandom_range(dr_pkg::SpanLo, 0);
      default: row.t_last = row.t_first - $urandom_range(1000, 1);
    endcase
    return row;
  endfunction

  // Result side: random back-pressure, one long hold on request, and checking.
  int stall_cnt;
  initial begin
    retarget_res_t want;
    out_if.ready = 1'b0;
    stall_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (awaited_q.size() == 0) begin
          $display("unexpected result transaction: next_bits %h", out_if.next_bits);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          if (out_if.next_bits !== want.next_bits)
            report("next_bits", out_if.next_bits, want.next_bits);
          if (out_if.retargeted !== want.retargeted)
            report("retargeted", 32'(out_if.retargeted), 32'(want.retargeted));
          if (out_if.hit_limit !== want.hit_limit)
            report("hit_limit", 32'(out_if.hit_limit), 32'(want.hit_limit));
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_cnt = 200;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall_cnt = draw_gap();
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed table; typed rows carry results that can be read off directly.
  header_row_t directed[] = '{
    '{32'h0, 32'h1d00ffff, 32'd100, 32'd0, 1'b1, '{32'h1d00ffff, 1'b0, 1'b0}},
    '{32'hfffffffe, 32'hffffffff, 32'hffffffff, 32'h0, 1'b1, '{32'hffffffff, 1'b0, 1'b0}},
    '{32'd2015, 32'h1d00ffff, 32'd1209600, 32'd0, 1'b1, '{32'h1d00ffff, 1'b1, 1'b0}},
    '{32'hffffffff, 32'h1c0ffff0, 32'd600000, 32'd0, 1'b0, '0},
    '{32'd2015, 32'h23123456, 32'd5, 32'd0, 1'b1, '{32'h1d00ffff, 1'b1, 1'b1}},
    '{32'd4031, 32'hff7fffff, 32'd5, 32'd0, 1'b1, '{32'h1d00ffff, 1'b1, 1'b1}},
    '{32'd4031, 32'h1d000000, 32'd9, 32'd9, 1'b1, '{32'h00000000, 1'b1, 1'b0}},
    '{32'd2015, 32'h1b0404cb, 32'd7, 32'd7, 1'b0, '0},
    '{32'd2015, 32'h1b0404cb, 32'd0, 32'd1, 1'b0, '0},
    '{32'd2015, 32'h1b0404cb, 32'hffffffff, 32'h0, 1'b0, '0},
    '{32'd2015, 32'h1a80ffff, 32'd1000000, 32'd0, 1'b0, '0},
    '{32'd2015, 32'h01123456, 32'd4000000, 32'd0, 1'b0, '0},
    '{32'd2015, 32'h02008000, 32'd4000000, 32'd0, 1'b0, '0},
    '{32'd2015, 32'h03000001, 32'd4000000, 32'd0, 1'b0, '0},
    '{32'd2015, 32'h00ffffff, 32'd4000000, 32'd0, 1'b0, '0},
    '{32'd2015, 32'h22000001, 32'd4000000, 32'd0, 1'b0, '0},
    '{32'd2015, 32'h2200ffff, 32'd4000000, 32'd0, 1'b1, '{32'h1d00ffff, 1'b1, 1'b1}},
    '{32'd2015, 32'h2100ffff, 32'd300000, 32'd0, 1'b1, '{32'h1d00ffff, 1'b1, 1'b1}},
    '{32'd2015, 32'h207fffff, 32'd302400, 32'd0, 1'b0, '0},
    '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1,
      '{32'h1d00ffff, 1'b1, 1'b1}}
  };

  // Stimulus: reset, directed table, then random phases over several limits.
  logic [31:0] limits[] = '{32'h00000000, 32'hffffffff, 32'h2100ffff, 32'h207fffff,
                            32'h03800001, 32'h1b0404cb, 32'h1d00ffff};
  initial begin
    errors = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    limit_reg = dr_pkg::LimitReset;
    rst_ni = 1'b0;
    limit_we_i = 1'b0;
    limit_wdata_i = '0;
    in_if.valid = 1'b0;
    in_if.last_height = '0;
    in_if.last_bits = '0;
    in_if.last_timestamp = '0;
    in_if.first_timestamp = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_header(directed[i]);
    drain();

    foreach (limits[p]) begin
      write_limit((p == limits.size() - 1) ? $urandom : limits[p]);
      // Back-to-back phases with no idling on either side.
      no_idle = (p % 3 == 1);
      // Long receiver hold while headers keep coming, filling the pipeline.
      if (p == 0) begin
        no_idle = 1'b1;
        hold_req = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 0 && n == 80) no_idle = 1'b0;
        // Sender pauses once until every result is back.
        if (p == 2 && n == PhaseItems / 2) drain();
        send_header(random_header());
      end
      drain();
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- difficulty_retarget.f -----
src/dr_pkg.sv
src/dr_if.sv
src/difficulty_retarget.sv
tb/testbench.sv
